// ----- hdl/arpc_pkg.sv -----
// Shared types and constants for the ARP responder cache.
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 2'd0;

    localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN   = 8'd4;
    localparam logic [15:0] OP_REQUEST       = 16'd1;
    localparam logic [15:0] OP_REPLY         = 16'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_FIELD  = 3'd1,
        ST_NOT_OURS   = 3'd2,
        ST_BAD_OPCODE = 3'd3,
        ST_MISS       = 3'd4
    } status_t;

    typedef struct packed {
        logic             func;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  query_ip;
    } in_t;

    typedef struct packed {
        status_t          status;
        logic             reply_valid;
        logic [MAC_W-1:0] reply_target_mac;
        logic [IP_W-1:0]  reply_target_ip;
        logic [MAC_W-1:0] found_mac;
        logic             insert_dropped;
    } out_t;

endpackage

// ----- hdl/arpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH  = 80,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/arpc_seq.sv -----
// Sequencer that checks a beat, scans the cache serially and builds the result.
`timescale 1ns / 1ps

module arpc_seq #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [arpc_pkg::IP_W-1:0]    own_ip,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  arpc_pkg::in_t                item,
    output logic                         res_valid,
    input  logic                         res_take,
    output arpc_pkg::out_t               res
);

    import arpc_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    addr_reg;
    logic             cmp_valid_reg;
    logic             func_reg;
    logic [15:0]      op_reg;
    logic [IP_W-1:0]  key_reg;
    logic [MAC_W-1:0] mac_reg;
    out_t             res_reg;

    logic               hdr_bad;
    logic               hit;
    logic               miss;
    logic               full;
    logic               ram_rd_en;
    logic               ram_wr_en;
    logic [ENTRY_W-1:0] ram_rd_data;

    function automatic out_t pkt_result(input logic [15:0] op, input logic [IP_W-1:0] ip,
                                        input logic [MAC_W-1:0] mac, input logic dropped);
        out_t r;
        r                = '0;
        r.status         = ST_OK;
        r.insert_dropped = dropped;
        if (op == OP_REQUEST) begin
            r.reply_valid      = 1'b1;
            r.reply_target_mac = mac;
            r.reply_target_ip  = ip;
        end else if (op != OP_REPLY) begin
            r.status = ST_BAD_OPCODE;
        end
        return r;
    endfunction

    function automatic out_t status_result(input status_t st);
        out_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    function automatic out_t found_result(input logic [MAC_W-1:0] mac);
        out_t r;
        r           = '0;
        r.status    = ST_OK;
        r.found_mac = mac;
        return r;
    endfunction

    assign hdr_bad = (item.hw_type != HW_TYPE_ETHERNET) ||
                     (item.proto_type != PROTO_TYPE_IPV4) ||
                     (item.hw_len != HW_ADDR_LEN) || (item.proto_len != PROTO_ADDR_LEN);

    // Entries fill from the bottom and are never removed, so the fill count
    // alone tells which entries are valid.
    assign full      = (count_reg == CW'(TABLE_ENTRIES));
    assign hit       = (state_reg == S_SCAN) && cmp_valid_reg &&
                       (ram_rd_data[ENTRY_W-1:MAC_W] == key_reg);
    assign miss      = (state_reg == S_SCAN) && !hit && (addr_reg == count_reg);
    assign ram_rd_en = (state_reg == S_SCAN) && !hit && (addr_reg != count_reg);
    assign ram_wr_en = miss && !func_reg && !full;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(AW)
    ) u_entries (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data({key_reg, mac_reg}),
        .rd_en  (ram_rd_en),
        .rd_addr(addr_reg[AW-1:0]),
        .rd_data(ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= ram_rd_en;
            case (state_reg)
                S_IDLE: begin
                    if (item_valid) begin
                        func_reg <= item.func;
                        op_reg   <= item.opcode;
                        mac_reg  <= item.sender_mac;
                        key_reg  <= item.func ? item.query_ip : item.sender_ip;
                        addr_reg <= '0;
                        if (!item.func && hdr_bad) begin
                            res_reg   <= status_result(ST_BAD_FIELD);
                            state_reg <= S_DONE;
                        end else if (!item.func && (item.target_ip != own_ip)) begin
                            res_reg   <= status_result(ST_NOT_OURS);
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (ram_rd_en) begin
                        addr_reg <= addr_reg + CW'(1);
                    end
                    if (hit) begin
                        if (func_reg) begin
                            res_reg <= found_result(ram_rd_data[MAC_W-1:0]);
                        end else begin
                            // A known sender keeps the MAC it was stored with.
                            res_reg <= pkt_result(op_reg, key_reg, mac_reg, 1'b0);
                        end
                        state_reg <= S_DONE;
                    end else if (miss) begin
                        if (func_reg) begin
                            res_reg <= status_result(ST_MISS);
                        end else begin
                            res_reg <= pkt_result(op_reg, key_reg, mac_reg, full);
                        end
                        if (ram_wr_en) begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

endmodule

// ----- hdl/arp_responder_cache_top.sv -----
// Top level of the ARP responder cache: configuration, sequencer and output register.
`timescale 1ns / 1ps

// The block takes one beat at a time on the s_ channel. A beat with func 0
// carries parsed ARP header fields; a beat with func 1 asks for the cached MAC
// of query_ip. Each beat yields exactly one result beat on the m_ channel.
// The station address is written through the cfg_ port; the user must write
// it only while the block idles, as the block itself does not enforce this.
// A beat that fails the header or target check goes to its result without a
// scan. Otherwise the cache is scanned one entry per cycle over the single
// read port of the entry memory, up to a hit or, for a miss, through all count
// entries, where count is the number of filled entries.
// s_ready is low from acceptance until the result has moved into the output
// register, so a new beat is taken only after the last one is through.
// Reset empties the cache at once through its fill count; no clearing pass is
// needed. When the receiver stalls, the result beat holds in the output
// register, and one further result waits inside the sequencer behind it.

module arp_responder_cache_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  arpc_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output arpc_pkg::out_t                    m_data,
    input  logic                              cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import arpc_pkg::*;

    logic [IP_W-1:0] own_ip_reg;
    logic            m_valid_reg;
    out_t            m_data_reg;
    logic            res_valid;
    logic            res_take;
    out_t            res;

    // The station MAC only feeds the framing of a reply, which is built
    // outside this block, so a write to that register has no effect here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_IP: begin
                    own_ip_reg <= cfg_wdata[IP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    arpc_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .own_ip    (own_ip_reg),
        .item_valid(s_valid),
        .item_ready(s_ready),
        .item      (s_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The sequencer works on one beat at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat was still in progress");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |=> m_valid_reg && (m_data_reg == $past(res)))
        else $error("finished result did not reach the output register");

    a_reply_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.reply_valid |-> m_data_reg.status == ST_OK)
        else $error("reply requested with a failing status");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status == ST_BAD_FIELD || m_data_reg.status == ST_NOT_OURS)
        |-> !m_data_reg.insert_dropped && !m_data_reg.reply_valid)
        else $error("rejected packet reported cache or reply activity");

endmodule

// ----- bench/arpc_tb_pkg.sv -----
// Register indexes and an opcode used by the ARP responder cache bench beyond those in the design package.
`timescale 1ns / 1ps

package arpc_tb_pkg;

    localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_OWN_MAC   = 2'd1;
    localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [arpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    // An opcode that is neither request nor reply.
    localparam logic [15:0] ARP_OP_UNKNOWN = 16'd3;

endpackage

// ----- bench/arp_responder_cache_checker.sv -----
// Checker for the ARP responder cache: predicts every result beat and compares it.
`timescale 1ns / 1ps

module arp_responder_cache_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  arpc_pkg::in_t                   s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  arpc_pkg::out_t                  m_data,
    input  logic                            cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending_results,
    output int                              checked_results,
    output int                              reply_count,
    output int                              hit_count,
    output int                              miss_count,
    output int                              drop_count
);

    import arpc_pkg::*;
    import arpc_tb_pkg::*;

    localparam int REPORT_LIMIT = 40;

    logic [IP_W-1:0]  station_ip;
    logic [MAC_W-1:0] station_mac;
    logic             cache_valid [TABLE_ENTRIES];
    logic [IP_W-1:0]  cache_ip    [TABLE_ENTRIES];
    logic [MAC_W-1:0] cache_mac   [TABLE_ENTRIES];

    out_t results_due[$];
    int   mismatches = 0;
    int   checked = 0;
    int   replies = 0;
    int   hits = 0;
    int   misses = 0;
    int   drops = 0;

    function automatic int find_slot(input logic [IP_W-1:0] ip);
        int slot;
        slot = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (cache_valid[i] && cache_ip[i] == ip) slot = i;
        end
        return slot;
    endfunction

    // Returns 1 when the pair is new and every entry is taken.
    function automatic logic store_pair(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        int free_slot;
        free_slot = -1;
        if (find_slot(ip) >= 0) return 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!cache_valid[i]) free_slot = i;
        end
        if (free_slot < 0) return 1'b1;
        cache_valid[free_slot] = 1'b1;
        cache_ip[free_slot]    = ip;
        cache_mac[free_slot]   = mac;
        return 1'b0;
    endfunction

    function automatic out_t arp_outcome(input in_t beat);
        out_t res;
        int   slot;
        res        = '0;
        res.status = ST_OK;
        if (beat.func) begin
            slot = find_slot(beat.query_ip);
            if (slot >= 0) res.found_mac = cache_mac[slot];
            else res.status = ST_MISS;
        end else if (beat.hw_type != HW_TYPE_ETHERNET || beat.proto_type != PROTO_TYPE_IPV4 ||
                     beat.hw_len != HW_ADDR_LEN || beat.proto_len != PROTO_ADDR_LEN) begin
            res.status = ST_BAD_FIELD;
        end else if (beat.target_ip != station_ip) begin
            res.status = ST_NOT_OURS;
        end else begin
            // The sender pair goes into the cache whatever the opcode turns out to be.
            res.insert_dropped = store_pair(beat.sender_ip, beat.sender_mac);
            if (beat.opcode == OP_REQUEST) begin
                res.reply_valid      = 1'b1;
                res.reply_target_mac = beat.sender_mac;
                res.reply_target_ip  = beat.sender_ip;
            end else if (beat.opcode != OP_REPLY) begin
                res.status = ST_BAD_OPCODE;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_t predicted;
        out_t want;
        if (!aresetn) begin
            station_ip  = '0;
            station_mac = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) cache_valid[i] = 1'b0;
            results_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OWN_IP:  station_ip = cfg_wdata[IP_W-1:0];
                    CFG_OWN_MAC: station_mac = cfg_wdata[MAC_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = arp_outcome(s_data);
                results_due.push_back(predicted);
                if (predicted.reply_valid) replies++;
                if (predicted.insert_dropped) drops++;
                if (predicted.status == ST_MISS) misses++;
                if (s_data.func && predicted.status == ST_OK) hits++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t ns: unexpected result beat: expected nothing, actual %h",
                                 $time, m_data);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", 64'(want.status), 64'(m_data.status));
                    check_field("reply_valid", 64'(want.reply_valid),
                                64'(m_data.reply_valid));
                    check_field("reply_target_mac", 64'(want.reply_target_mac),
                                64'(m_data.reply_target_mac));
                    check_field("reply_target_ip", 64'(want.reply_target_ip),
                                64'(m_data.reply_target_ip));
                    check_field("found_mac", 64'(want.found_mac), 64'(m_data.found_mac));
                    check_field("insert_dropped", 64'(want.insert_dropped),
                                64'(m_data.insert_dropped));
                    checked++;
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= results_due.size();
        checked_results <= checked;
        reply_count     <= replies;
        hit_count       <= hits;
        miss_count      <= misses;
        drop_count      <= drops;
    end

endmodule

// ----- bench/arp_responder_cache_top_tb.sv -----
// Bench top for the ARP responder cache: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module arp_responder_cache_top_tb;

    import arpc_pkg::*;
    import arpc_tb_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_BEATS = 205;
    localparam int POOL_SIZE     = 20;
    // Room to spare beyond the time a miss over a full table takes.
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 2000;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_SENDER_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending_results;
    int checked_results;
    int reply_count;
    int hit_count;
    int miss_count;
    int drop_count;

    int              sender_idle_pct = 0;
    int              receiver_idle_pct = 0;
    logic [IP_W-1:0] station_ip = '0;
    int              beats_sent = 0;
    int              settings_used = 0;

    always #4 aclk = ~aclk;

    arp_responder_cache_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    arp_responder_cache_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .checked_results (checked_results),
        .reply_count     (reply_count),
        .hit_count       (hit_count),
        .miss_count      (miss_count),
        .drop_count      (drop_count)
    );

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("arp_responder_cache_top regression: fail");
        $finish;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [IP_W-1:0] pool_ip(input int k);
        return {24'h0A0000, 8'(k)};
    endfunction

    function automatic in_t noise_beat();
        in_t beat;
        beat.func       = 1'($urandom);
        beat.hw_type    = 16'($urandom);
        beat.proto_type = 16'($urandom);
        beat.hw_len     = 8'($urandom);
        beat.proto_len  = 8'($urandom);
        beat.opcode     = 16'($urandom);
        beat.sender_mac = rand_mac();
        beat.sender_ip  = $urandom;
        beat.target_ip  = $urandom;
        beat.query_ip   = $urandom;
        return beat;
    endfunction

    function automatic in_t arp_packet(input logic [15:0] op, input logic [IP_W-1:0] sip,
                                       input logic [MAC_W-1:0] smac);
        in_t beat;
        beat            = noise_beat();
        beat.func       = 1'b0;
        beat.hw_type    = HW_TYPE_ETHERNET;
        beat.proto_type = PROTO_TYPE_IPV4;
        beat.hw_len     = HW_ADDR_LEN;
        beat.proto_len  = PROTO_ADDR_LEN;
        beat.opcode     = op;
        beat.sender_mac = smac;
        beat.sender_ip  = sip;
        beat.target_ip  = station_ip;
        return beat;
    endfunction

    function automatic in_t lookup_beat(input logic [IP_W-1:0] qip);
        in_t beat;
        beat          = noise_beat();
        beat.func     = 1'b1;
        beat.query_ip = qip;
        return beat;
    endfunction

    // Half well-formed packets to us; the rest lookups, broken or misaddressed packets and noise.
    function automatic in_t random_beat();
        in_t             beat;
        int              pick;
        int              op_pick;
        logic [IP_W-1:0] sip;
        logic [15:0]     op;
        pick = $urandom_range(99);
        sip  = ($urandom_range(99) < 85) ? pool_ip($urandom_range(POOL_SIZE - 1)) : $urandom;
        if (pick < 30) begin
            beat = lookup_beat(sip);
            if ($urandom_range(99) < 30) beat.query_ip = $urandom;
            return beat;
        end
        if (pick >= 90) begin
            beat      = noise_beat();
            beat.func = 1'b0;
            return beat;
        end
        op_pick = $urandom_range(19);
        if (op_pick < 9) op = OP_REQUEST;
        else if (op_pick < 16) op = OP_REPLY;
        else op = 16'($urandom);
        beat = arp_packet(op, sip, rand_mac());
        if (pick >= 80) begin
            case ($urandom_range(4))
                0: beat.hw_type ^= 16'($urandom_range(65535, 1));
                1: beat.proto_type ^= 16'($urandom_range(65535, 1));
                2: beat.hw_len ^= 8'($urandom_range(255, 1));
                3: beat.proto_len ^= 8'($urandom_range(255, 1));
                default: beat.target_ip ^= ($urandom | 32'h1);
            endcase
        end
        return beat;
    endfunction

    function automatic bit sender_pauses();
        return $urandom_range(99) < sender_idle_pct;
    endfunction

    // Valid stays high across back-to-back beats; it only drops when a gap is taken.
    task automatic send_beat(input in_t beat);
        if (sender_pauses()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (sender_pauses());
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OWN_IP;
        cfg_wdata <= {16'($urandom), ip};
        @(posedge aclk);
        cfg_index <= CFG_OWN_MAC;
        cfg_wdata <= mac;
        @(posedge aclk);
        // A write to an unmapped index must leave both station registers alone.
        cfg_index <= ($urandom_range(1) != 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI;
        cfg_wdata <= rand_mac();
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        station_ip  = ip;
        settings_used++;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER_LIGHT: begin
                sender_idle_pct   <= 35;
                receiver_idle_pct <= 51;
            end
            IDLE_SENDER_HEAVY: begin
                sender_idle_pct   <= 51;
                receiver_idle_pct <= 35;
            end
            default: begin
                sender_idle_pct   <= 0;
                receiver_idle_pct <= 0;
            end
        endcase
    endtask

    initial begin
        in_t beat;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(IDLE_SENDER_LIGHT);

        // Station address still at its reset value of zero, cache empty.
        send_beat(lookup_beat('0));
        send_beat(arp_packet(OP_REQUEST, 32'hC0A8_0A0A, '1));
        drain();
        configure(32'hC0A8_0001, 48'h0200_5E00_0001);

        beat = arp_packet(OP_REQUEST, 32'h0A0A_0A0A, rand_mac());
        beat.hw_type = '0;
        send_beat(beat);
        beat.hw_type    = HW_TYPE_ETHERNET;
        beat.proto_type = 16'h0806;
        send_beat(beat);
        beat.proto_type = PROTO_TYPE_IPV4;
        beat.hw_len     = '1;
        send_beat(beat);
        beat.hw_len    = HW_ADDR_LEN;
        beat.proto_len = '0;
        send_beat(beat);
        beat.proto_len = PROTO_ADDR_LEN;
        beat.target_ip = station_ip ^ 32'h1;
        send_beat(beat);
        beat.target_ip = '1;
        send_beat(beat);

        send_beat(arp_packet(OP_REQUEST, '1, '0));
        send_beat(arp_packet(OP_REPLY, '0, rand_mac()));
        send_beat(arp_packet('0, 32'h0A0A_0A0B, rand_mac()));
        send_beat(arp_packet('1, 32'h0A0A_0A0C, rand_mac()));
        send_beat(arp_packet(ARP_OP_UNKNOWN, 32'h0A0A_0A0D, rand_mac()));
        // A known sender address keeps the MAC it was first stored with.
        send_beat(arp_packet(OP_REQUEST, '1, '1));
        send_beat(lookup_beat('1));
        send_beat(lookup_beat(32'hC0A8_0A0A));
        send_beat(lookup_beat('0));
        send_beat(lookup_beat(32'h1234_5678));

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            if (seg < 3) set_idling(IDLE_SENDER_LIGHT);
            else if (seg < 6) set_idling(IDLE_SENDER_HEAVY);
            else set_idling(IDLE_NONE);
            case (seg % 4)
                1: configure('0, '0);
                2: configure('1, '1);
                default: configure($urandom, rand_mac());
            endcase
            repeat (SEGMENT_BEATS) send_beat(random_beat());
        end
        drain();

        $display("Sent %0d packet and lookup beats under %0d station settings %s",
                 beats_sent, settings_used, "and three idling mixes.");
        $display("Checked %0d results: %0d replies, %0d hits, %0d misses, %0d dropped inserts.",
                 checked_results, reply_count, hit_count, miss_count, drop_count);
        if (fail_count == 0) begin
            $display("arp_responder_cache_top regression: pass");
        end else begin
            $display("arp_responder_cache_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_seq.sv
hdl/arp_responder_cache_top.sv
bench/arpc_tb_pkg.sv
bench/arp_responder_cache_checker.sv
bench/arp_responder_cache_top_tb.sv
